FILE: design/quarter_rate_mixer_decimator_assert.svh
// Assertion macros for the quarter-rate mixer and decimator.
`ifndef QUARTER_RATE_MIXER_DECIMATOR_ASSERT_SVH
`define QUARTER_RATE_MIXER_DECIMATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define QRMD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrmd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define QRMD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrmd: next-cycle check failed");

`endif

FILE: design/qrmd_pkg.sv
// Package: codes, widths and reset values for the quarter-rate mixer and decimator.
package qrmd_pkg;

	// Operation codes of an input request
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_ARM    = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	// Result kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Register indexes of the configuration port
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BACKFILL_COUNT = 2'd1;

	// Field widths
	localparam int SAMPLE_WIDTH = 16;
	localparam int MIXED_WIDTH  = SAMPLE_WIDTH + 1;
	localparam int ACC_WIDTH    = 19;
	localparam int INDEX_WIDTH  = 18;
	localparam int REG_WIDTH    = 18;

	// Defaults and reset values
	localparam int COUNT_WIDTH_DEFAULT = 18;
	localparam int TARGET_RESET        = 180000;
	localparam int BACKFILL_RESET      = 0;

	// Last mixer phase of a group of four
	localparam logic [1:0] PHASE_LAST = 2'd3;

endpackage

FILE: design/quarter_rate_mixer_decimator.sv
// Top level: quarter-rate mixer with four-sample boxcar decimator for a capture buffer.
//
// Takes one request per cycle unless stalled (sample, arm or finish) and gives at most one
// result for each: every fourth sample of an armed capture yields a decimated
// sample (sum of I, Q, -I, -Q by mixer phase, scale 2^0 of the input LSB) with its buffer
// index, and a finish yields the count reached. Sustained rate is one request
// per clock while results are not stalled; a request passes the input register,
// a single select-and-add and the result register before its result is offered.
// Configuration writes are always taken (cfg_ready is tied high) and must only
// happen while the block is idle. COUNT_WIDTH sets the width of the capture
// counter and the target and backfill registers.
`include "quarter_rate_mixer_decimator_assert.svh"

module quarter_rate_mixer_decimator
	import qrmd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]       cfg_index,
	input  logic [REG_WIDTH-1:0]             cfg_data,
	// input requests
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [1:0]                       operation,
	input  logic signed [SAMPLE_WIDTH-1:0]   in_phase,
	input  logic signed [SAMPLE_WIDTH-1:0]   quadrature,
	// results
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic                             kind,
	output logic [INDEX_WIDTH-1:0]           sample_index,
	output logic signed [ACC_WIDTH-1:0]      sample_value,
	output logic                             reached_target
);

	// Configuration registers
	logic [COUNT_WIDTH-1:0] target_q;
	logic [COUNT_WIDTH-1:0] backfill_q;
	logic [COUNT_WIDTH-1:0] cfg_value_c;

	// Input stage
	logic                           valid_s1;
	logic [1:0]                     op_s1;
	logic signed [SAMPLE_WIDTH-1:0] i_s1;
	logic signed [SAMPLE_WIDTH-1:0] q_s1;

	// Capture state; the phase also counts the items in the accumulator
	logic                        armed_q;
	logic [1:0]                  phase_q;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic [COUNT_WIDTH-1:0]      count_q;

	// Result stage
	logic                        valid_s2;
	logic                        kind_s2;
	logic [INDEX_WIDTH-1:0]      index_s2;
	logic signed [ACC_WIDTH-1:0] value_s2;
	logic                        reached_s2;

	// Datapath
	logic                          out_free_c;
	logic                          advance_c;
	logic                          target_hit_c;
	logic                          take_sample_c;
	logic                          emit_c;
	logic                          emit_kind_c;
	logic signed [MIXED_WIDTH-1:0] mixed_c;
	logic signed [ACC_WIDTH-1:0]   acc_sum_c;
	logic [COUNT_WIDTH-1:0]        arm_count_c;

	assign cfg_ready   = 1'b1;
	assign cfg_value_c = COUNT_WIDTH'(cfg_data);

	// Handshake: the input stage moves whenever the result slot is free or draining
	assign out_free_c = !valid_s2 || !result_stall;
	assign advance_c  = valid_s1 && out_free_c;
	assign item_stall = valid_s1 && !out_free_c;

	// Mixer select: real part of the rotation 1, -j, -1, +j
	always_comb begin
		unique case (phase_q)
			2'd0:    mixed_c = MIXED_WIDTH'(i_s1);
			2'd1:    mixed_c = MIXED_WIDTH'(q_s1);
			2'd2:    mixed_c = -MIXED_WIDTH'(i_s1);
			default: mixed_c = -MIXED_WIDTH'(q_s1);
		endcase
	end

	assign acc_sum_c     = acc_q + ACC_WIDTH'(mixed_c);
	assign target_hit_c  = count_q >= target_q;
	assign take_sample_c = (op_s1 == OP_SAMPLE) && armed_q && !target_hit_c;
	assign arm_count_c   = (backfill_q > target_q) ? target_q : backfill_q;

	// Result decision
	always_comb begin
		emit_c      = 1'b0;
		emit_kind_c = KIND_SAMPLE;
		if (op_s1 == OP_FINISH) begin
			emit_c      = 1'b1;
			emit_kind_c = KIND_FINISH;
		end else if (take_sample_c && phase_q == PHASE_LAST) begin
			emit_c = 1'b1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= COUNT_WIDTH'(TARGET_RESET);
			backfill_q <= COUNT_WIDTH'(BACKFILL_RESET);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_TARGET_COUNT) begin
				target_q <= cfg_value_c;
			end else if (cfg_index == REG_BACKFILL_COUNT) begin
				backfill_q <= cfg_value_c;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1 <= operation;
			i_s1  <= in_phase;
			q_s1  <= quadrature;
		end
	end

	// Capture state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			phase_q <= 2'd0;
			acc_q   <= '0;
			count_q <= '0;
		end else if (advance_c) begin
			if (op_s1 == OP_ARM) begin
				if (target_q != '0) begin
					armed_q <= 1'b1;
					phase_q <= 2'd0;
					acc_q   <= '0;
					count_q <= arm_count_c;
				end
			end else if (op_s1 == OP_FINISH) begin
				armed_q <= 1'b0;
			end else if (take_sample_c) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == PHASE_LAST) begin
					acc_q   <= '0;
					count_q <= count_q + COUNT_WIDTH'(1);
				end else begin
					acc_q <= acc_sum_c;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free_c) begin
			valid_s2 <= advance_c && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_c && emit_c) begin
			kind_s2  <= emit_kind_c;
			index_s2 <= INDEX_WIDTH'(count_q);
			if (emit_kind_c == KIND_FINISH) begin
				value_s2   <= '0;
				reached_s2 <= target_hit_c;
			end else begin
				value_s2   <= acc_sum_c;
				reached_s2 <= 1'b0;
			end
		end
	end

	assign result_valid   = valid_s2;
	assign kind           = kind_s2;
	assign sample_index   = index_s2;
	assign sample_value   = value_s2;
	assign reached_target = reached_s2;

	// Checks
	`QRMD_ASSERT_NOW(a_acc_clear_at_group_start, phase_q == 2'd0, acc_q == '0)
	`QRMD_ASSERT_NOW(a_full_pipe_stalls, valid_s1 && valid_s2 && result_stall, item_stall)
	`QRMD_ASSERT_NEXT(a_finish_disarms, advance_c && op_s1 == OP_FINISH, !armed_q && valid_s2)
	`QRMD_ASSERT_NEXT(a_sample_bumps_count,
		advance_c && take_sample_c && phase_q == PHASE_LAST,
		count_q == $past(count_q) + COUNT_WIDTH'(1) && valid_s2 && kind_s2 == KIND_SAMPLE)

endmodule
